FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the correspondence table.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/tct_pkg.sv
// Types and constants for the track correspondence table.
// No dependencies; used by track_correspondence_table.
package tct_pkg;

    localparam int IMG_W   = 16;
    localparam int PT_W    = 24;
    localparam int IDX_W   = 6;
    localparam int CNT_O_W = 7;
    localparam int RPT_W   = 16;

    typedef logic [1:0]         t_cmd;
    typedef logic [IMG_W-1:0]   t_img;
    typedef logic [PT_W-1:0]    t_pt;

    localparam t_cmd CMD_ADD      = 2'd0;
    localparam t_cmd CMD_CONTAINS = 2'd1;
    localparam t_cmd CMD_LOOKUP   = 2'd2;
    localparam t_cmd CMD_READ     = 2'd3;

    typedef struct packed {
        t_img image;
        t_pt  point;
    } t_entry;

endpackage

FILE: hdl/track_correspondence_table.sv
// Track correspondence table: one feature track of (image, point) pairs in a
// single-port-write, registered-read memory. Depends on tct_pkg, assert_macros.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command item: add pair,
//   contains query, pair lookup, or read entry by index. Output channel
//   (o_valid / i_ready) returns exactly one result item per command.
//   Each command reads the table one entry per cycle through the memory's
//   read port: scanning commands (add, contains, lookup) visit every stored
//   pair, at most MAX_VIEWS of them; read visits the entry at its index, or
//   none for an index past the count. An item passes from acceptance through
//   the scan state and the final state, where the result is registered, to
//   the next acceptance. An add on an inconsistent track skips the scan.
//   The result sits in an output register, so a new item is accepted while a
//   result still waits; if the receiver keeps stalling, the next command
//   holds in its final cycle until the output register frees up.
//   Reset clears the count, the repeat counter and the inconsistent flag;
//   table contents are left as they are and are never read past the count.
//   The add write-back happens in the final cycle, before any later scan.
module track_correspondence_table #(
    parameter int MAX_VIEWS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tct_pkg::t_cmd               i_command,
    input  tct_pkg::t_img               i_image,
    input  tct_pkg::t_pt                i_point,
    input  tct_pkg::t_img               i_second_image,
    input  logic [tct_pkg::IDX_W-1:0]   i_entry_index,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_status,
    output logic                        o_found_first,
    output logic                        o_found_second,
    output tct_pkg::t_pt                o_point_a,
    output tct_pkg::t_pt                o_point_b,
    output tct_pkg::t_img               o_image_out,
    output logic [tct_pkg::CNT_O_W-1:0] o_entry_count,
    output logic                        o_table_full
);

`include "assert_macros.svh"

    localparam int AW = (MAX_VIEWS > 1) ? $clog2(MAX_VIEWS) : 1;
    localparam int CW = $clog2(MAX_VIEWS + 1);
    localparam int XW = (CW > tct_pkg::IDX_W) ? CW : tct_pkg::IDX_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    tct_pkg::t_entry r_mem [MAX_VIEWS];
    tct_pkg::t_entry r_rd_data;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [tct_pkg::RPT_W-1:0] r_repeat, n_repeat;
    logic                    r_incons, n_incons;
    logic [CW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_end, n_end;
    logic                    r_rd_vld;
    logic                    scan_issue;

    // latched command
    tct_pkg::t_cmd           r_cmd;
    tct_pkg::t_img           r_img, r_img2;
    tct_pkg::t_pt            r_pt;

    // scan results
    logic                    r_hit1, r_hit2, r_hitc;
    tct_pkg::t_pt            r_pt1, r_pt2;
    tct_pkg::t_img           r_img_rd;

    // output register
    logic                    r_out_vld;
    logic                    out_free, fin_go;
    logic                    mem_we;
    logic                    n_status, n_f1, n_f2, n_full;
    tct_pkg::t_pt            n_pa, n_pb;
    tct_pkg::t_img           n_iout;
    logic                    r_status, r_f1, r_f2, r_full;
    tct_pkg::t_pt            r_pa, r_pb;
    tct_pkg::t_img           r_iout;
    logic [tct_pkg::CNT_O_W-1:0] r_cnt_o;

    logic                    idx_ok;
    logic                    m1, m2;

    assign o_ready    = (r_state == ST_IDLE);
    assign scan_issue = (r_state == ST_SCAN) && (r_ptr < r_end);
    assign out_free   = !r_out_vld || i_ready;
    assign fin_go     = (r_state == ST_FIN) && out_free;
    assign idx_ok     = XW'(i_entry_index) < XW'(r_count);
    assign m1         = (r_rd_data.image == r_img);
    assign m2         = (r_rd_data.image == r_img2);

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= '{image: r_img, point: r_pt};
        end
        if (scan_issue) begin
            r_rd_data <= r_mem[r_ptr[AW-1:0]];
        end
    end

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_end   = r_end;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                    n_ptr   = '0;
                    n_end   = r_count;
                    if (i_command == tct_pkg::CMD_READ) begin
                        n_ptr = idx_ok ? CW'(i_entry_index) : '0;
                        n_end = idx_ok ? CW'(i_entry_index) + 1'b1 : '0;
                    end else if (i_command == tct_pkg::CMD_ADD && r_incons) begin
                        n_end = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_issue) begin
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    // nothing in flight once issuing stops
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // final-cycle result and write-back
    always_comb begin
        n_count  = r_count;
        n_repeat = r_repeat;
        n_incons = r_incons;
        mem_we   = 1'b0;
        n_status = 1'b0;
        n_f1     = 1'b0;
        n_f2     = 1'b0;
        n_full   = 1'b0;
        n_pa     = '0;
        n_pb     = '0;
        n_iout   = '0;
        unique case (r_cmd)
            tct_pkg::CMD_ADD: begin
                if (!r_incons) begin
                    n_status = 1'b1;
                    if (r_hit1) begin
                        if (r_pt1 == r_pt) begin
                            if (r_repeat != '1) begin
                                n_repeat = r_repeat + 1'b1;
                            end
                        end else begin
                            n_incons = 1'b1;
                            n_status = 1'b0;
                        end
                    end else if (r_count < CW'(MAX_VIEWS)) begin
                        mem_we  = fin_go;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_full = 1'b1;
                    end
                end
            end
            tct_pkg::CMD_CONTAINS: begin
                n_status = r_hitc;
            end
            tct_pkg::CMD_LOOKUP: begin
                n_f1 = r_hit1;
                n_f2 = r_hit2;
                n_pa = r_hit1 ? r_pt1 : '0;
                n_pb = r_hit2 ? r_pt2 : '0;
            end
            tct_pkg::CMD_READ: begin
                n_status = r_hit1;
                n_pa     = r_hit1 ? r_pt1 : '0;
                n_iout   = r_hit1 ? r_img_rd : '0;
            end
            default: n_status = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_repeat  <= '0;
            r_incons  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_ptr     <= '0;
            r_end     <= '0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_end    <= n_end;
            r_rd_vld <= scan_issue;
            if (fin_go) begin
                r_count  <= n_count;
                r_repeat <= n_repeat;
                r_incons <= n_incons;
            end
            if (fin_go) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_valid) begin
            r_cmd  <= i_command;
            r_img  <= i_image;
            r_img2 <= i_second_image;
            r_pt   <= i_point;
            r_hit1 <= 1'b0;
            r_hit2 <= 1'b0;
            r_hitc <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_cmd == tct_pkg::CMD_READ) begin
                r_hit1   <= 1'b1;
                r_pt1    <= r_rd_data.point;
                r_img_rd <= r_rd_data.image;
            end else begin
                // first match wins for each image
                if (m1 && !r_hit1) begin
                    r_hit1 <= 1'b1;
                    r_pt1  <= r_rd_data.point;
                end
                if (m2 && !r_hit2) begin
                    r_hit2 <= 1'b1;
                    r_pt2  <= r_rd_data.point;
                end
                if (m1 && r_rd_data.point == r_pt) begin
                    r_hitc <= 1'b1;
                end
            end
        end
        if (fin_go) begin
            r_status <= n_status;
            r_f1     <= n_f1;
            r_f2     <= n_f2;
            r_full   <= n_full;
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_iout   <= n_iout;
            r_cnt_o  <= tct_pkg::CNT_O_W'(n_count);
        end
    end

    assign o_valid        = r_out_vld;
    assign o_status       = r_status;
    assign o_found_first  = r_f1;
    assign o_found_second = r_f2;
    assign o_point_a      = r_pa;
    assign o_point_b      = r_pb;
    assign o_image_out    = r_iout;
    assign o_entry_count  = r_cnt_o;
    assign o_table_full   = r_full;

    // ---------------------------------------------------------------- checks
    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_VIEWS), "count over capacity")
    `ASSERT_IMPL(a_rd_in_scan, i_clk, i_rst_n, r_rd_vld, r_state == ST_SCAN, "read data outside scan")
    `ASSERT_NEXT(a_incons_sticky, i_clk, i_rst_n, r_incons, r_incons, "inconsistent flag cleared")
    `ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1, (r_count == $past(r_count)) || (r_count == $past(r_count) + 1'b1), "count jumped")

endmodule
